FILE: hw/rtl/urep_pkg.sv
`timescale 1ns / 1ps
package urep_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int WIN     = 4;

    typedef logic [2:0] t_len;

    localparam t_len LEN_BAD   = 3'd0;
    localparam t_len LEN_ASCII = 3'd1;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    typedef struct packed {
        logic [7:0] data;
        logic       text_end;
        t_len       len;
    } t_item;

    function automatic t_len lead_len(input logic [7:0] b);
        t_len l;
        if (b < 8'h80) begin
            l = LEN_ASCII;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            l = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            l = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            l = 3'd4;
        end else begin
            l = LEN_BAD;
        end
        return l;
    endfunction

    function automatic logic is_tail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // judge a complete multi-byte sequence of length 2..4
    function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input t_len len);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] cp3;
        logic [15:0] cp4;
        logic        rng;
        logic        ok;
        lo = 8'h80;
        hi = 8'hBF;
        if (b0 == 8'hE0) begin
            lo = 8'hA0;
        end else if (b0 == 8'hED) begin
            hi = 8'h9F;
        end else if (b0 == 8'hF0) begin
            lo = 8'h90;
        end else if (b0 == 8'hF4) begin
            hi = 8'h8F;
        end
        rng = (b1 >= lo) && (b1 <= hi);
        cp3 = {b0[3:0], b1[5:0], b2[5:0]};
        cp4 = {b1[3:0], b2[5:0], b3[5:0]};
        if (len == 3'd2) begin
            ok = is_tail(b1);
        end else if (len == 3'd3) begin
            // noncharacters fdd0..fdef and fffe/ffff are rejected
            ok = rng && is_tail(b2) && !(cp3 >= 16'hFFFE ||
                 (cp3 >= 16'hFDD0 && cp3 <= 16'hFDEF));
        end else begin
            ok = rng && is_tail(b2) && is_tail(b3) && (cp4 < 16'hFFFE);
        end
        return ok;
    endfunction

endpackage

FILE: hw/rtl/urep_if.sv
`timescale 1ns / 1ps
interface urep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface urep_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;

    modport source (output valid, output out_byte, output was_replaced,
                    output run_last, input ready);
    modport sink (input valid, input out_byte, input was_replaced,
                  input run_last, output ready);
endinterface

FILE: hw/rtl/urep_front.sv
`timescale 1ns / 1ps
module urep_front (
    urep_in_if.sink       i_in,
    input  logic          i_q_ready,
    output logic          o_q_push,
    output urep_pkg::t_item o_q_item
);
    import urep_pkg::*;

    assign i_in.ready        = i_q_ready;
    assign o_q_push          = i_in.valid && i_q_ready;
    assign o_q_item.data     = i_in.in_byte;
    assign o_q_item.text_end = i_in.text_end;
    // classify the lead byte once on entry
    assign o_q_item.len      = lead_len(i_in.in_byte);

endmodule

FILE: hw/rtl/urep_fifo.sv
`timescale 1ns / 1ps
module urep_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  urep_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output urep_pkg::t_item o_item
);
    import urep_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_ready = r_cnt != (Q_AW + 1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/urep_back.sv
`timescale 1ns / 1ps
module urep_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  urep_pkg::t_item i_q_item,
    output logic            o_q_pop,
    urep_out_if.source      o_out
);
    import urep_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_JUDGE = 2'd1;
    localparam logic [1:0] ST_PASS  = 2'd2;
    localparam logic [1:0] ST_REPL  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [7:0] r_wb [WIN];
    logic [7:0] n_wb [WIN];
    t_len       r_wl [WIN];
    t_len       n_wl [WIN];
    logic [2:0] r_n, n_n;
    logic       r_end, n_end;
    logic [1:0] r_pass, n_pass;
    logic       r_rep, n_rep;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_repl;
    logic       r_out_last;

    logic       adv;
    logic       emit;
    logic [7:0] e_byte;
    logic       e_repl;
    logic       e_last;
    logic       shift;
    logic [2:0] n_minus1;
    logic       w0_wait;
    logic       w0_ok;
    logic       w1_wait;
    logic       more1;

    assign adv      = !r_out_valid || o_out.ready;
    assign n_minus1 = r_n - 3'd1;
    assign w0_wait  = (r_wl[0] != LEN_BAD) && (r_wl[0] > r_n);
    assign w0_ok    = (r_wl[0] != LEN_BAD) && !w0_wait &&
                      seq_ok(r_wb[0], r_wb[1], r_wb[2], r_wb[3], r_wl[0]);
    // would the byte behind the head give a result after a one-byte shift
    assign w1_wait  = (r_wl[1] != LEN_BAD) && (r_wl[1] > n_minus1) && !r_end;
    assign more1    = (r_n > 3'd1) && !w1_wait;

    always_comb begin
        n_state = r_state;
        n_wb    = r_wb;
        n_wl    = r_wl;
        n_n     = r_n;
        n_end   = r_end;
        n_pass  = r_pass;
        n_rep   = r_rep;
        emit    = 1'b0;
        e_byte  = r_wb[0];
        e_repl  = 1'b0;
        e_last  = 1'b0;
        shift   = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop            = 1'b1;
                    n_wb[r_n[1:0]]     = i_q_item.data;
                    n_wl[r_n[1:0]]     = i_q_item.len;
                    n_n                = r_n + 3'd1;
                    n_end              = i_q_item.text_end;
                    n_state            = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (r_n == 3'd0) begin
                    n_state = ST_LOAD;
                end else if (r_wl[0] == LEN_ASCII) begin
                    if (adv) begin
                        emit    = 1'b1;
                        shift   = 1'b1;
                        e_last  = !more1;
                        n_state = more1 ? ST_JUDGE : ST_LOAD;
                    end
                end else if (w0_wait && !r_end) begin
                    n_state = ST_LOAD;
                end else if (w0_ok) begin
                    if (adv) begin
                        emit    = 1'b1;
                        shift   = 1'b1;
                        n_pass  = 2'(r_wl[0] - 3'd1);
                        n_state = ST_PASS;
                    end
                end else begin
                    if (adv) begin
                        emit    = 1'b1;
                        e_byte  = REPL_B0;
                        e_repl  = 1'b1;
                        n_rep   = 1'b0;
                        n_state = ST_REPL;
                    end
                end
            end
            ST_PASS: begin
                if (adv) begin
                    emit   = 1'b1;
                    shift  = 1'b1;
                    n_pass = r_pass - 2'd1;
                    if (r_pass == 2'd1) begin
                        e_last  = !more1;
                        n_state = more1 ? ST_JUDGE : ST_LOAD;
                    end
                end
            end
            ST_REPL: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_repl = 1'b1;
                    if (!r_rep) begin
                        e_byte = REPL_B1;
                        n_rep  = 1'b1;
                    end else begin
                        e_byte  = REPL_B2;
                        shift   = 1'b1;
                        e_last  = !more1;
                        n_rep   = 1'b0;
                        n_state = more1 ? ST_JUDGE : ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
        if (shift) begin
            for (int i = 0; i < WIN - 1; i++) begin
                n_wb[i] = r_wb[i+1];
                n_wl[i] = r_wl[i+1];
            end
            n_n = n_minus1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb   <= n_wb;
        r_wl   <= n_wl;
        r_end  <= n_end;
        r_pass <= n_pass;
        r_rep  <= n_rep;
        if (adv && emit) begin
            r_out_byte <= e_byte;
            r_out_repl <= e_repl;
            r_out_last <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.was_replaced = r_out_repl;
    assign o_out.run_last     = r_out_last;

    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 3'd4)
        else $error("window count out of range");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_n <= 3'd3))
        else $error("no room to load a byte");

    a_pass_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> (r_pass != 2'd0) && (r_n != 3'd0))
        else $error("pass-through with nothing left");

    a_repl_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_repl) |->
        (r_out_byte == REPL_B0 || r_out_byte == REPL_B1 || r_out_byte == REPL_B2))
        else $error("replacement flag on a foreign byte");

    a_emit_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && o_q_pop))
        else $error("load and emit in one cycle");

endmodule

FILE: hw/rtl/utf8_invalid_byte_replacer_top.sv
`timescale 1ns / 1ps
// path: an accepted byte goes through the queue, is loaded into the window in the load state and is
// judged in the judge state; each result byte is registered at the output in its own step, and a
// byte that leaves a sequence incomplete gets a judge step with no result before the next load
// no byte is loaded while a result is emitted, and the output holding off stalls every emit step
// reset: synchronous active low, clears the queue, held byte count and output valid
module utf8_invalid_byte_replacer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    urep_in_if.sink     i_in,
    urep_out_if.source  o_out
);
    import urep_pkg::*;

    logic  q_push;
    logic  q_ready;
    logic  q_pop;
    logic  q_valid;
    t_item q_in;
    t_item q_out;

    urep_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_item  (q_in)
    );

    urep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    urep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: sim/tb_utf8_invalid_byte_replacer_top.sv
`timescale 1ns / 1ps
module tb_utf8_invalid_byte_replacer_top;

    import urep_pkg::REPL_B0;
    import urep_pkg::REPL_B1;
    import urep_pkg::REPL_B2;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       last;
    } t_repaired_byte;

    logic i_clk;
    logic i_rst_n;

    urep_in_if  u_in_if ();
    urep_out_if u_out_if ();

    utf8_invalid_byte_replacer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    t_text_byte     text_q[$];
    t_repaired_byte repaired_q[$];
    logic [7:0]     held_bytes[$];
    logic [7:0]     chr[$];
    t_text_byte     next_byte;
    t_repaired_byte want;

    int n_sent;
    int n_accepted;
    int n_results;
    int n_errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    logic hold_done;
    int stall_cycles;

    always #4 i_clk = ~i_clk;

    // sequence length announced by a lead byte, 0 when it cannot lead
    function automatic int seq_len(input logic [7:0] b);
        if (!b[7]) return 1;
        if (b >= 8'hC2 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF4) return 4;
        return 0;
    endfunction

    function automatic logic code_ok(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input int len);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] cp;
        lo = 8'h80;
        hi = 8'hBF;
        case (b0)
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
        endcase
        if (len == 2) return b1[7:6] == 2'b10;
        if (b1 < lo || b1 > hi || b2[7:6] != 2'b10) return 1'b0;
        if (len == 3) begin
            cp = {b0[3:0], b1[5:0], b2[5:0]};
            return !(cp >= 16'hFFFE || (cp >= 16'hFDD0 && cp <= 16'hFDEF));
        end
        if (b3[7:6] != 2'b10) return 1'b0;
        cp = {b1[3:0], b2[5:0], b3[5:0]};
        return cp < 16'hFFFE;
    endfunction

    task automatic emit(input logic [7:0] b, input logic r);
        repaired_q.push_back('{data: b, repl: r, last: 1'b0});
    endtask

    // predict the repaired bytes caused by one accepted text byte
    task automatic repair_byte(input logic [7:0] b, input logic last);
        logic [7:0] w[$];
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        int         len;
        int         used;
        int         start;
        int         i;
        logic       waiting;
        w = held_bytes;
        w.push_back(b);
        start = repaired_q.size();
        waiting = 1'b0;
        while (w.size() > 0 && !waiting) begin
            len = seq_len(w[0]);
            c1 = (w.size() > 1) ? w[1] : 8'h00;
            c2 = (w.size() > 2) ? w[2] : 8'h00;
            c3 = (w.size() > 3) ? w[3] : 8'h00;
            used = 1;
            if (len == 1) begin
                emit(w[0], 1'b0);
            end else if (len != 0 && len > w.size() && !last) begin
                waiting = 1'b1;
                used = 0;
            end else if (len != 0 && len <= w.size() && code_ok(w[0], c1, c2, c3, len)) begin
                for (i = 0; i < len; i++) emit(w[i], 1'b0);
                used = len;
            end else begin
                emit(REPL_B0, 1'b1);
                emit(REPL_B1, 1'b1);
                emit(REPL_B2, 1'b1);
            end
            repeat (used) void'(w.pop_front());
        end
        held_bytes = w;
        if (repaired_q.size() > start) repaired_q[repaired_q.size() - 1].last = 1'b1;
    endtask

    task automatic send(input logic [7:0] b, input logic last);
        text_q.push_back('{data: b, last: last});
        n_sent++;
    endtask

    function automatic logic pick_end();
        return $urandom_range(0, 11) == 0;
    endfunction

    // well-formed sequence with random content, now and then a noncharacter
    task automatic make_seq(input int len);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] b1;
        int         i;
        chr.delete();
        case (len)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
        b1 = 8'($urandom_range(lo, hi));
        chr.push_back(lead);
        chr.push_back(b1);
        for (i = 2; i < len; i++) chr.push_back(8'($urandom_range(8'h80, 8'hBF)));
        if (len == 3 && $urandom_range(0, 5) == 0) begin
            chr[0] = 8'hEF;
            if ($urandom_range(0, 1) == 1) begin
                chr[1] = 8'hB7;
                chr[2] = 8'($urandom_range(8'h90, 8'hAF));
            end else begin
                chr[1] = 8'hBF;
                chr[2] = 8'($urandom_range(8'hBE, 8'hBF));
            end
        end else if (len == 4 && $urandom_range(0, 5) == 0) begin
            chr[1] = {b1[7:4], 4'hF};
            chr[2] = 8'hBF;
            chr[3] = 8'($urandom_range(8'hBE, 8'hBF));
        end
    endtask

    task automatic push_seq(input logic last);
        int i;
        for (i = 0; i < chr.size(); i++) send(chr[i], last && i == chr.size() - 1);
    endtask

    task automatic gen_char();
        int         kind;
        int         cut;
        int         pos;
        logic [7:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send(8'($urandom_range(0, 127)), pick_end());
        end else if (kind < 80) begin
            make_seq(kind < 45 ? 2 : (kind < 65 ? 3 : 4));
            push_seq(pick_end());
        end else if (kind < 88) begin
            send(8'($urandom_range(0, 255)), pick_end());
        end else if (kind < 95) begin
            // cut short, often right at the end of the text
            make_seq($urandom_range(2, 4));
            cut = $urandom_range(1, chr.size() - 1);
            repeat (cut) void'(chr.pop_back());
            push_seq(1'($urandom_range(0, 1)));
        end else begin
            make_seq($urandom_range(2, 4));
            pos = $urandom_range(1, chr.size() - 1);
            v = 8'($urandom_range(0, 191));
            if (v >= 8'h80) v = v + 8'h40;
            chr[pos] = v;
            push_seq(pick_end());
        end
    endtask

    task automatic random_text(input int n);
        int target;
        target = n_sent + n;
        while (n_sent < target) gen_char();
    endtask

    task automatic wait_drained();
        while (n_accepted != n_sent || repaired_q.size() != 0) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else begin
            if (u_in_if.valid && u_in_if.ready) begin
                repair_byte(u_in_if.in_byte, u_in_if.text_end);
                n_accepted++;
            end
            if (!u_in_if.valid || u_in_if.ready) begin
                if (text_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_byte = text_q.pop_front();
                    u_in_if.valid    <= 1'b1;
                    u_in_if.in_byte  <= next_byte.data;
                    u_in_if.text_end <= next_byte.last;
                end else begin
                    u_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                n_results++;
                if (repaired_q.size() == 0) begin
                    $display("%0t: expected no transaction, actual out_byte %02h was_replaced %b run_last %b",
                             $time, u_out_if.out_byte, u_out_if.was_replaced,
                             u_out_if.run_last);
                    n_errors++;
                end else begin
                    want = repaired_q.pop_front();
                    if (u_out_if.out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, u_out_if.out_byte);
                        n_errors++;
                    end
                    if (u_out_if.was_replaced !== want.repl) begin
                        $display("%0t: was_replaced expected %b actual %b",
                                 $time, want.repl, u_out_if.was_replaced);
                        n_errors++;
                    end
                    if (u_out_if.run_last !== want.last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, u_out_if.run_last);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block fills up and stalls its input
            if (hold_left > 0) begin
                hold_left--;
                u_out_if.ready <= 1'b0;
            end else if (!hold_done && n_results >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                u_out_if.ready <= 1'b0;
            end else begin
                u_out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in_if.valid && u_in_if.ready) ||
            (u_out_if.valid && u_out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        u_in_if.valid = 1'b0;
        u_in_if.in_byte = 8'h00;
        u_in_if.text_end = 1'b0;
        u_out_if.ready = 1'b0;
        n_sent = 0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;
        hold_left = 0;
        hold_done = 1'b0;
        stall_cycles = 0;
        send_idle_pct = 26;
        recv_idle_pct = 45;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ascii extremes and the edges of the 2-, 3- and 4-byte ranges
        send(8'h00, 1'b0);
        send(8'h7F, 1'b0);
        send(8'hC2, 1'b0); send(8'h80, 1'b0);
        send(8'hDF, 1'b0); send(8'hBF, 1'b0);
        send(8'hE0, 1'b0); send(8'hA0, 1'b0); send(8'h80, 1'b0);
        // noncharacter in the fdd0 block, then the top of the 4-byte range, the noncharacter 10ffff
        send(8'hEF, 1'b0); send(8'hB7, 1'b0); send(8'h90, 1'b0);
        send(8'hF4, 1'b0); send(8'h8F, 1'b0); send(8'hBF, 1'b0); send(8'hBF, 1'b0);
        // bytes that cannot lead
        send(8'hF5, 1'b0); send(8'hC0, 1'b0); send(8'h80, 1'b0);
        // bad tail, then a sequence cut off at the end of the text
        send(8'hC2, 1'b0); send(8'h41, 1'b0);
        send(8'hF0, 1'b0); send(8'h90, 1'b0); send(8'h80, 1'b1);
        random_text(95);
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 26;
        random_text(95);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_text(96);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: utf8_invalid_byte_replacer_top.f
hw/rtl/urep_pkg.sv
hw/rtl/urep_if.sv
hw/rtl/urep_front.sv
hw/rtl/urep_fifo.sv
hw/rtl/urep_back.sv
hw/rtl/utf8_invalid_byte_replacer_top.sv
sim/tb_utf8_invalid_byte_replacer_top.sv
